// ----- hw/rtl/spc_pkg.sv -----
`timescale 1ns / 1ps

package spc_pkg;

  localparam int unsigned WAYS_W = 30;
  localparam int unsigned MASK_W = 32;

  // Prime modulus for all path counts
  localparam logic [WAYS_W-1:0] WAYS_MOD = 30'd1000000009;

  typedef struct packed {
    logic blocked;
    logic first_stair;
    logic top_stair;
  } spc_in_t;

  typedef struct packed {
    logic [WAYS_W-1:0] ways;
    logic              is_answer;
  } spc_out_t;

  // Shared controls broadcast along the cell row
  typedef struct packed {
    logic adv;      // shift the row by one stair
    logic zero_in;  // drop the partial sum coming from the upper neighbor
  } spc_ctl_t;

endpackage

// ----- hw/rtl/spc_cell.sv -----
`timescale 1ns / 1ps

// One position of the row: a history count and the partial sum owed to a future stair.
module spc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spc_pkg::spc_ctl_t             ctl,
  input  logic                          hop_en,
  input  logic [spc_pkg::WAYS_W-1:0]    feed,
  input  logic [spc_pkg::WAYS_W-1:0]    hist_in,
  input  logic [spc_pkg::WAYS_W-1:0]    psum_in,
  output logic [spc_pkg::WAYS_W-1:0]    hist_q,
  output logic [spc_pkg::WAYS_W-1:0]    psum_q
);

  logic [spc_pkg::WAYS_W-1:0] hist_r;
  logic [spc_pkg::WAYS_W-1:0] hist_nxt;
  logic [spc_pkg::WAYS_W-1:0] psum_r;
  logic [spc_pkg::WAYS_W-1:0] psum_nxt;
  logic [spc_pkg::WAYS_W-1:0] add_a;
  logic [spc_pkg::WAYS_W-1:0] add_b;
  logic [spc_pkg::WAYS_W:0]   sum;
  logic [spc_pkg::WAYS_W:0]   mod_ext;

  always_comb begin
    add_a   = ctl.zero_in ? '0 : psum_in;
    add_b   = hop_en ? feed : '0;
    sum     = {1'b0, add_a} + {1'b0, add_b};
    mod_ext = {1'b0, spc_pkg::WAYS_MOD};
    hist_nxt = hist_r;
    psum_nxt = psum_r;
    if (ctl.adv) begin
      hist_nxt = hist_in;
      // both operands stay below the modulus, so one subtract folds it back
      if (sum >= mod_ext) begin
        psum_nxt = spc_pkg::WAYS_W'(sum - mod_ext);
      end else begin
        psum_nxt = sum[spc_pkg::WAYS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      psum_r <= '0;
    end else begin
      hist_r <= hist_nxt;
      psum_r <= psum_nxt;
    end
  end

  assign hist_q = hist_r;
  assign psum_q = psum_r;

endmodule

// ----- hw/rtl/spc_skid.sv -----
`timescale 1ns / 1ps

// Output register plus one skid entry; accepts a push while the head is stalled.
module spc_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spc_pkg::spc_out_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output spc_pkg::spc_out_t out_data
);

  logic              head_v_r;
  logic              head_v_nxt;
  spc_pkg::spc_out_t head_r;
  spc_pkg::spc_out_t head_nxt;
  logic              skid_v_r;
  logic              skid_v_nxt;
  spc_pkg::spc_out_t skid_r;
  spc_pkg::spc_out_t skid_nxt;

  always_comb begin
    head_v_nxt = head_v_r;
    head_nxt   = head_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!head_v_r || !out_stall) begin
      // head is free this cycle: refill from skid first, else from the push
      head_v_nxt = skid_v_r | push;
      head_nxt   = skid_v_r ? skid_r : push_data;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

endmodule

// ----- hw/rtl/stair_path_count_mod_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  spc_in_t  (blocked, first_stair, top_stair)
// out_      output     out_valid/out_stall  spc_out_t (ways, is_answer)
// cfg_      input      cfg_wr_en            cfg_wr_data = step_mask, no read-back
//
// One stair per cycle while in_stall is low; a taken stair's result is registered.
// Throughput is set by the row head: its partial sum is the stair count, and
// every cell enabled in step_mask adds it to its partial sum in the same cycle.
// A step_mask write starts a rebuild pass that replays the stored history
// through the row; in_stall stays high during the pass.
// Synchronous reset leaves all counts zero and step_mask = 1; no clearing pass.
// A stalled output holds in the output register; one more transaction lands in
// the skid entry before in_stall rises.
module stair_path_count_mod_unit #(
  parameter int unsigned MAX_STEP = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  spc_pkg::spc_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output spc_pkg::spc_out_t          out_data,
  input  logic                       cfg_wr_en,
  input  logic [spc_pkg::MASK_W-1:0] cfg_wr_data
);

  localparam int unsigned ROT_W = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
  localparam logic [ROT_W-1:0] ROT_LAST = ROT_W'(MAX_STEP - 1);

  // Cell i holds the count of the stair i+1 below and the partial sum owed to
  // the stair i+1 above; the head's partial sum is the next stair's count.
  logic [spc_pkg::WAYS_W-1:0] hist_q  [MAX_STEP];
  logic [spc_pkg::WAYS_W-1:0] psum_q  [MAX_STEP];
  logic [spc_pkg::WAYS_W-1:0] hist_in [MAX_STEP];
  logic [spc_pkg::WAYS_W-1:0] psum_in [MAX_STEP];
  logic [MAX_STEP-1:0]        hop_en;

  logic [spc_pkg::MASK_W-1:0] step_mask_r;
  logic [spc_pkg::MASK_W-1:0] step_mask_nxt;
  logic                       busy_r;
  logic                       busy_nxt;
  logic                       dirty_r;
  logic                       dirty_nxt;
  logic [ROT_W-1:0]           rot_r;
  logic [ROT_W-1:0]           rot_nxt;

  logic                       accept;
  logic                       clr_hist;
  logic                       skid_full;
  logic [spc_pkg::WAYS_W-1:0] feed;
  spc_pkg::spc_ctl_t          ctl;
  spc_pkg::spc_out_t          result;

  assign in_stall = busy_r | skid_full;
  assign accept   = in_valid & ~in_stall;
  assign clr_hist = accept & in_data.first_stair;

  // Value pushed into the row: the stair count, or the oldest history entry
  // while rebuilding so the history rotates back into place.
  always_comb begin
    if (busy_r) begin
      feed = hist_q[MAX_STEP-1];
    end else if (in_data.first_stair) begin
      feed = in_data.blocked ? '0 : spc_pkg::WAYS_W'(1);
    end else if (in_data.blocked) begin
      feed = '0;
    end else begin
      feed = psum_q[0];
    end
  end

  always_comb begin
    ctl.adv     = accept | busy_r;
    ctl.zero_in = busy_r ? (rot_r == '0) : in_data.first_stair;
  end

  generate
    for (genvar i = 0; i < MAX_STEP; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign hist_in[i] = feed;
      end else begin : g_body
        assign hist_in[i] = clr_hist ? '0 : hist_q[i-1];
      end
      if (i == MAX_STEP - 1) begin : g_tail
        assign psum_in[i] = '0;
      end else begin : g_link
        assign psum_in[i] = psum_q[i+1];
      end
      // hop sizes beyond the mask width never apply
      if (i < spc_pkg::MASK_W) begin : g_hop
        assign hop_en[i] = step_mask_r[i];
      end else begin : g_nohop
        assign hop_en[i] = 1'b0;
      end

      spc_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .hop_en  (hop_en[i]),
        .feed    (feed),
        .hist_in (hist_in[i]),
        .psum_in (psum_in[i]),
        .hist_q  (hist_q[i]),
        .psum_q  (psum_q[i])
      );
    end
  endgenerate

  // Rebuild sequencing: a mask write during a pass forces one more full pass
  // so every partial sum reflects the final mask.
  always_comb begin
    step_mask_nxt = cfg_wr_en ? cfg_wr_data : step_mask_r;
    busy_nxt      = busy_r;
    dirty_nxt     = dirty_r;
    rot_nxt       = rot_r;
    if (!busy_r) begin
      if (cfg_wr_en) begin
        busy_nxt  = 1'b1;
        dirty_nxt = 1'b0;
        rot_nxt   = '0;
      end
    end else if (rot_r == ROT_LAST) begin
      rot_nxt   = '0;
      dirty_nxt = 1'b0;
      busy_nxt  = dirty_r | cfg_wr_en;
    end else begin
      rot_nxt   = rot_r + 1'b1;
      dirty_nxt = dirty_r | cfg_wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_mask_r <= spc_pkg::MASK_W'(1);
      busy_r      <= 1'b0;
      dirty_r     <= 1'b0;
      rot_r       <= '0;
    end else begin
      step_mask_r <= step_mask_nxt;
      busy_r      <= busy_nxt;
      dirty_r     <= dirty_nxt;
      rot_r       <= rot_nxt;
    end
  end

  assign result.ways      = feed;
  assign result.is_answer = in_data.top_stair;

  spc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Hold off input for the rebuild pass that a mask write starts.
  assert property (@(posedge clk) disable iff (!rst_n) cfg_wr_en |=> in_stall)
    else $error("input open right after a step_mask write");

  // After a taken transaction, out_valid must be high on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // The head partial sum is the next count and must stay reduced.
  assert property (@(posedge clk) disable iff (!rst_n) psum_q[0] < spc_pkg::WAYS_MOD)
    else $error("head partial sum not reduced");

  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid |-> (out_data.ways < spc_pkg::WAYS_MOD))
    else $error("output count out of range");

  // Rotation counter parks at zero so the history is aligned when idle.
  assert property (@(posedge clk) disable iff (!rst_n) !busy_r |-> (rot_r == '0))
    else $error("history left rotated after rebuild");

endmodule

// ----- verif/stair_path_count_mod_unit_tb.sv -----
`timescale 1ns / 1ps

// Checks stair_path_count_mod_unit against its own copy of the stair count.
// Each stair transaction is predicted when it is put on the input channel.
// Transactions are taken in the order they are presented, so each prediction
// queues in order. The result side pops one expectation per taken result and
// compares it field by field. Both channels idle on patterns of their own.
// step_mask is changed only while nothing is in flight.
module stair_path_count_mod_unit_tb;

  localparam int unsigned HOPS       = 32;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned PHASE_LEN  = 166;
  localparam int unsigned PRINT_CAP  = 200;

  typedef enum int {STALL_OFF, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  spc_pkg::spc_in_t           in_data;
  logic                       out_valid;
  logic                       out_stall;
  spc_pkg::spc_out_t          out_data;
  logic                       cfg_wr_en;
  logic [spc_pkg::MASK_W-1:0] cfg_wr_data;

  // Predictor state: counts of the last HOPS stairs, newest first, and the mask.
  logic [spc_pkg::WAYS_W-1:0] stair_counts[HOPS];
  logic [spc_pkg::MASK_W-1:0] hop_mask;

  spc_pkg::spc_out_t          pending_ways[$];
  int unsigned                error_count;
  int unsigned                cycle_count;
  int                         burst_left;

  stair_path_count_mod_unit #(
    .MAX_STEP(HOPS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Advance the stair count by one stair and return the expected result.
  // A first stair clears the window and starts at one way (zero if blocked);
  // any other open stair sums the counts one allowed hop below it.
  function automatic spc_pkg::spc_out_t count_stair(spc_pkg::spc_in_t s);
    longint unsigned   sum;
    spc_pkg::spc_out_t r;
    sum = 0;
    if (s.first_stair) begin
      for (int d = 0; d < HOPS; d++) stair_counts[d] = '0;
      sum = s.blocked ? 0 : 1;
    end else if (!s.blocked) begin
      for (int d = 0; d < HOPS; d++) begin
        if (d < spc_pkg::MASK_W && hop_mask[d]) sum += stair_counts[d];
      end
    end
    sum = sum % longint'(spc_pkg::WAYS_MOD);
    for (int d = HOPS - 1; d > 0; d--) stair_counts[d] = stair_counts[d-1];
    stair_counts[0] = sum[spc_pkg::WAYS_W-1:0];
    r.ways      = sum[spc_pkg::WAYS_W-1:0];
    r.is_answer = s.top_stair;
    return r;
  endfunction

  function automatic spc_pkg::spc_in_t stair_item(bit blk, bit first, bit top);
    spc_pkg::spc_in_t s;
    s.blocked     = blk;
    s.first_stair = first;
    s.top_stair   = top;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Result side: take a transaction whenever valid is up and we are not stalling.
  always @(posedge clk) begin
    spc_pkg::spc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ways.size() == 0) begin
        report_mismatch("unexpected result ways", out_data.ways, -1);
      end else begin
        want = pending_ways.pop_front();
        if (out_data.ways !== want.ways)
          report_mismatch("ways", out_data.ways, want.ways);
        if (out_data.is_answer !== want.is_answer)
          report_mismatch("is_answer", out_data.is_answer, want.is_answer);
      end
    end
  end

  // Receiver back-pressure: switch between stall modes after each random-length span,
  // including long stretches with no stall at all.
  initial begin
    stall_mode_t mode;
    int          span;
    int          period;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      mode   = stall_mode_t'($urandom_range(0, 3));
      span   = $urandom_range(16, 160);
      period = $urandom_range(2, 9);
      for (int k = 0; k < span; k++) begin
        case (mode)
          STALL_OFF:      out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          default:        out_stall <= ((k % period) < (period / 2));
        endcase
        @(posedge clk);
      end
    end
  end

  // Present one stair and hold it until taken. Bursts of random length are
  // separated by random gaps; valid stays high across a burst.
  task automatic send_stair(input spc_pkg::spc_in_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    pending_ways.push_back(count_stair(s));
    in_data  <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid at the end of a phase; step once so the next raise lands later.
  task automatic end_phase();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // Write step_mask only once every outstanding result has drained.
  task automatic set_hop_mask(input logic [spc_pkg::MASK_W-1:0] mask);
    while (pending_ways.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    hop_mask    = mask;
  endtask

  // Nothing started since reset: every stair must count zero.
  task automatic test_no_first_stair();
    send_stair(stair_item(1'b0, 1'b0, 1'b0));
    send_stair(stair_item(1'b1, 1'b0, 1'b0));
    send_stair(stair_item(1'b0, 1'b0, 1'b1));
    end_phase();
  endtask

  // Hops of 1 and 2, a blocked stair mid-flight, and a top stair that is not
  // the end of the flight.
  task automatic test_basic_climb();
    set_hop_mask(32'h0000_0003);
    send_stair(stair_item(1'b0, 1'b1, 1'b0));
    send_stair(stair_item(1'b0, 1'b0, 1'b0));
    send_stair(stair_item(1'b0, 1'b0, 1'b0));
    send_stair(stair_item(1'b1, 1'b0, 1'b0));
    send_stair(stair_item(1'b0, 1'b0, 1'b0));
    send_stair(stair_item(1'b0, 1'b0, 1'b1));
    send_stair(stair_item(1'b0, 1'b0, 1'b0));
    send_stair(stair_item(1'b0, 1'b0, 1'b1));
    end_phase();
  endtask

  // A blocked first stair zeroes the whole flight, blocked top included.
  task automatic test_blocked_first();
    send_stair(stair_item(1'b1, 1'b1, 1'b0));
    send_stair(stair_item(1'b0, 1'b0, 1'b0));
    send_stair(stair_item(1'b1, 1'b0, 1'b1));
    send_stair(stair_item(1'b0, 1'b0, 1'b1));
    end_phase();
  endtask

  // Every hop size allowed: hops that reach below stair 1 add nothing.
  task automatic test_all_hops();
    set_hop_mask(32'hFFFF_FFFF);
    send_stair(stair_item(1'b0, 1'b1, 1'b0));
    for (int k = 0; k < 5; k++) send_stair(stair_item(1'b0, 1'b0, k == 4));
    end_phase();
  endtask

  // Mostly well-formed flights with random content; some long enough to fill
  // the window and wrap the modulus. The rest are loose random stairs.
  task automatic test_random_flights(input logic [spc_pkg::MASK_W-1:0] mask,
                                     input int n_items);
    int sent;
    int flight;
    bit blk;
    bit top;
    set_hop_mask(mask);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        send_stair(spc_pkg::spc_in_t'(3'($urandom_range(0, 7))));
        sent++;
      end else begin
        flight = ($urandom_range(0, 4) == 0) ? $urandom_range(34, 80) : $urandom_range(1, 33);
        for (int k = 0; k < flight; k++) begin
          blk = ($urandom_range(0, 99) < ((k == 0) ? 5 : 8));
          top = (k == flight - 1) || ($urandom_range(0, 49) == 0);
          send_stair(stair_item(blk, k == 0, top));
          sent++;
        end
      end
    end
    end_phase();
  endtask

  initial begin
    error_count  = 0;
    cycle_count  = 0;
    burst_left   = 0;
    hop_mask     = 32'h0000_0001;
    for (int d = 0; d < HOPS; d++) stair_counts[d] = '0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_first_stair();
    test_basic_climb();
    test_blocked_first();
    test_all_hops();

    // Sweep masks: the extremes, single hops at both ends, and random ones.
    test_random_flights(32'h0000_0003, PHASE_LEN);
    test_random_flights(32'hFFFF_FFFF, PHASE_LEN);
    test_random_flights(32'h0000_0000, PHASE_LEN);
    test_random_flights(32'h8000_0001, PHASE_LEN);
    test_random_flights(32'h8000_0000, PHASE_LEN);
    test_random_flights($urandom, PHASE_LEN);
    test_random_flights($urandom & $urandom, PHASE_LEN);
    test_random_flights(32'h0000_0001, PHASE_LEN);

    // Drain, then keep the clock running so any stray result can show.
    while (pending_ways.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
